// ----- src/i2cbm_pkg.sv -----
`default_nettype none

package i2cbm_pkg;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_SEND  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_WAIT  = 3'd5;

    localparam logic [1:0] REG_LONG_DELAY  = 2'd0;
    localparam logic [1:0] REG_SHORT_DELAY = 2'd1;
    localparam logic [1:0] REG_READ_DELAY  = 2'd2;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd3;

    localparam logic [7:0] LONG_DELAY_RST  = 8'd5;
    localparam logic [7:0] SHORT_DELAY_RST = 8'd2;
    localparam logic [7:0] READ_DELAY_RST  = 8'd4;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
        logic       rejected;
    } t_out_item;

    // classified request as it sits in the queue
    typedef struct packed {
        logic       is_cmd;
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic [7:0] long_delay;
        logic [7:0] short_delay;
        logic [7:0] read_delay;
        logic [7:0] ack_timeout;
    } t_cfg;

    function automatic logic [7:0] fn_ticks(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

`default_nettype wire

// ----- src/i2cbm_front.sv -----
`default_nettype none

module i2cbm_front (
    input  wire logic                 i_valid,
    input  wire i2cbm_pkg::t_in_item  i_data,
    output logic                      o_stall,
    input  wire i2cbm_pkg::t_q_status i_q_status,
    output logic                      o_push,
    output i2cbm_pkg::t_entry         o_entry
);
    import i2cbm_pkg::*;

    // hold off the sender only while the queue is full
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid & ~i_q_status.full;

    always_comb begin
        o_entry.is_cmd   = (i_data.action >= CMD_START) && (i_data.action <= CMD_WAIT);
        o_entry.action   = i_data.action;
        o_entry.tx_byte  = i_data.tx_byte;
        o_entry.send_ack = i_data.send_ack;
        o_entry.sda_in   = i_data.sda_in;
    end

endmodule

`default_nettype wire

// ----- src/i2cbm_queue.sv -----
`default_nettype none

module i2cbm_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire i2cbm_pkg::t_entry i_entry,
    input  wire logic              i_pop,
    output i2cbm_pkg::t_entry      o_entry,
    output i2cbm_pkg::t_q_status   o_status
);
    import i2cbm_pkg::*;

    t_entry     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop) r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_entry;
    end

    assign o_entry        = r_mem[r_rptr];
    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);

endmodule

`default_nettype wire

// ----- src/i2cbm_back.sv -----
`default_nettype none

module i2cbm_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire i2cbm_pkg::t_cfg      i_cfg,
    input  wire i2cbm_pkg::t_entry    i_entry,
    input  wire i2cbm_pkg::t_q_status i_q_status,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output i2cbm_pkg::t_out_item      o_data
);
    import i2cbm_pkg::*;

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_ST_A      = 5'd1;
    localparam logic [4:0] PH_ST_B      = 5'd2;
    localparam logic [4:0] PH_SP_A      = 5'd3;
    localparam logic [4:0] PH_SP_B      = 5'd4;
    localparam logic [4:0] PH_TX_PRE    = 5'd5;
    localparam logic [4:0] PH_TX_DATA   = 5'd6;
    localparam logic [4:0] PH_TX_HIGH   = 5'd7;
    localparam logic [4:0] PH_TX_LOW    = 5'd8;
    localparam logic [4:0] PH_RX_LOW    = 5'd9;
    localparam logic [4:0] PH_RX_HIGH   = 5'd10;
    localparam logic [4:0] PH_AK_LOW    = 5'd11;
    localparam logic [4:0] PH_AK_DATA   = 5'd12;
    localparam logic [4:0] PH_AK_DATA_X = 5'd13;
    localparam logic [4:0] PH_AK_HIGH   = 5'd14;
    localparam logic [4:0] PH_AK_HIGH_X = 5'd15;
    localparam logic [4:0] PH_WA_REL    = 5'd16;
    localparam logic [4:0] PH_WA_HIGH   = 5'd17;
    localparam logic [4:0] PH_WA_POLL   = 5'd18;

    logic [4:0] r_phase, n_phase;
    logic [2:0] r_cmd, n_cmd;
    logic [7:0] r_tick, n_tick;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_poll, n_poll;
    logic       r_ack, n_ack;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_rx, n_rx;
    logic       r_out_valid;
    t_out_item  r_out;

    logic done_now;
    logic fail_now;
    logic rej_now;
    logic sda;

    // advance the sequence only when the result register can take the tick
    assign o_pop = ~i_q_status.empty & (~r_out_valid | ~i_stall);
    assign sda   = i_entry.sda_in;

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_poll   = r_poll;
        n_ack    = r_ack;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_rx     = r_rx;
        done_now = 1'b0;
        fail_now = 1'b0;
        rej_now  = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_entry.is_cmd) begin
                n_cmd   = i_entry.action;
                n_bit   = 4'd0;
                n_poll  = 8'd0;
                n_shift = i_entry.tx_byte;
                n_ack   = i_entry.send_ack;
                case (i_entry.action)
                    CMD_START: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_phase = PH_ST_A;
                        n_tick  = fn_ticks(i_cfg.long_delay);
                    end
                    CMD_STOP: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        n_phase = PH_SP_A;
                        n_tick  = fn_ticks(i_cfg.long_delay);
                    end
                    CMD_SEND: begin
                        n_scl   = 1'b0;
                        n_phase = PH_TX_PRE;
                        n_tick  = fn_ticks(i_cfg.short_delay);
                    end
                    CMD_READ: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b0;
                        n_shift = 8'd0;
                        n_phase = PH_RX_LOW;
                        n_tick  = fn_ticks(i_cfg.read_delay);
                    end
                    default: begin
                        n_sda   = 1'b1;
                        n_phase = PH_WA_REL;
                        n_tick  = fn_ticks(i_cfg.short_delay);
                    end
                endcase
            end
        end else begin
            rej_now = i_entry.is_cmd;
            if (r_tick != 8'd0) n_tick = r_tick - 8'd1;
            if (n_tick == 8'd0) begin
                case (r_phase)
                    PH_ST_A: begin
                        n_sda   = 1'b0;
                        n_phase = PH_ST_B;
                        n_tick  = fn_ticks(i_cfg.long_delay);
                    end
                    PH_ST_B: begin
                        n_scl    = 1'b0;
                        n_phase  = PH_IDLE;
                        done_now = 1'b1;
                    end
                    PH_SP_A: begin
                        n_sda   = 1'b1;
                        n_phase = PH_SP_B;
                        n_tick  = fn_ticks(i_cfg.long_delay);
                    end
                    PH_SP_B: begin
                        n_scl    = 1'b0;
                        fail_now = (r_cmd == CMD_WAIT);
                        n_phase  = PH_IDLE;
                        done_now = 1'b1;
                    end
                    PH_TX_PRE: begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_phase = PH_TX_DATA;
                        n_tick  = fn_ticks(i_cfg.long_delay);
                    end
                    PH_TX_DATA: begin
                        n_scl   = 1'b1;
                        n_phase = PH_TX_HIGH;
                        n_tick  = fn_ticks(i_cfg.long_delay);
                    end
                    PH_TX_HIGH: begin
                        n_scl   = 1'b0;
                        n_phase = PH_TX_LOW;
                        n_tick  = fn_ticks(i_cfg.long_delay);
                    end
                    PH_TX_LOW: begin
                        n_bit = r_bit + 4'd1;
                        if (n_bit < 4'd8) begin
                            n_sda   = r_shift[7];
                            n_shift = {r_shift[6:0], 1'b0};
                            n_phase = PH_TX_DATA;
                            n_tick  = fn_ticks(i_cfg.long_delay);
                        end else begin
                            n_phase  = PH_IDLE;
                            done_now = 1'b1;
                        end
                    end
                    PH_RX_LOW: begin
                        n_scl   = 1'b1;
                        n_shift = {r_shift[6:0], sda};
                        n_phase = PH_RX_HIGH;
                        n_tick  = fn_ticks(i_cfg.read_delay);
                    end
                    PH_RX_HIGH: begin
                        n_bit = r_bit + 4'd1;
                        n_scl = 1'b0;
                        if (n_bit < 4'd8) begin
                            n_sda   = 1'b1;
                            n_phase = PH_RX_LOW;
                            n_tick  = fn_ticks(i_cfg.read_delay);
                        end else begin
                            n_rx    = r_shift;
                            n_phase = PH_AK_LOW;
                            n_tick  = fn_ticks(i_cfg.short_delay);
                        end
                    end
                    PH_AK_LOW: begin
                        n_sda   = ~r_ack;
                        n_phase = PH_AK_DATA;
                        n_tick  = fn_ticks(i_cfg.short_delay);
                    end
                    PH_AK_DATA: begin
                        if (r_ack) begin
                            n_phase = PH_AK_DATA_X;
                        end else begin
                            n_scl   = 1'b1;
                            n_phase = PH_AK_HIGH;
                        end
                        n_tick = fn_ticks(i_cfg.short_delay);
                    end
                    PH_AK_DATA_X: begin
                        n_scl   = 1'b1;
                        n_phase = PH_AK_HIGH;
                        n_tick  = fn_ticks(i_cfg.short_delay);
                    end
                    PH_AK_HIGH: begin
                        if (r_ack) begin
                            n_phase = PH_AK_HIGH_X;
                            n_tick  = fn_ticks(i_cfg.short_delay);
                        end else begin
                            n_scl    = 1'b0;
                            n_phase  = PH_IDLE;
                            done_now = 1'b1;
                        end
                    end
                    PH_AK_HIGH_X: begin
                        n_scl    = 1'b0;
                        n_phase  = PH_IDLE;
                        done_now = 1'b1;
                    end
                    PH_WA_REL: begin
                        n_scl   = 1'b1;
                        n_phase = PH_WA_HIGH;
                        n_tick  = fn_ticks(i_cfg.short_delay);
                    end
                    PH_WA_HIGH, PH_WA_POLL: begin
                        if (!sda) begin
                            n_scl    = 1'b0;
                            n_phase  = PH_IDLE;
                            done_now = 1'b1;
                        end else if (r_poll >= i_cfg.ack_timeout) begin
                            // no ACK in time: drop into a stop condition
                            n_scl   = 1'b1;
                            n_sda   = 1'b0;
                            n_phase = PH_SP_A;
                            n_tick  = fn_ticks(i_cfg.long_delay);
                        end else begin
                            n_poll  = r_poll + 8'd1;
                            n_phase = PH_WA_POLL;
                            n_tick  = fn_ticks(i_cfg.short_delay);
                        end
                    end
                    default: begin
                        n_phase  = PH_IDLE;
                        done_now = 1'b1;
                    end
                endcase
                if (done_now) n_tick = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cmd       <= CMD_NONE;
            r_tick      <= 8'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_poll      <= 8'd0;
            r_ack       <= 1'b0;
            r_scl       <= 1'b0;
            r_sda       <= 1'b1;
            r_rx        <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_tick  <= n_tick;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_poll  <= n_poll;
                r_ack   <= n_ack;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_rx    <= n_rx;
            end
            r_out_valid <= o_pop | (r_out_valid & i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.scl_level   <= n_scl;
            r_out.sda_release <= n_sda;
            r_out.busy_res    <= (n_phase != PH_IDLE);
            r_out.done_res    <= done_now;
            r_out.rx_byte     <= n_rx;
            r_out.ack_failed  <= fail_now;
            r_out.rejected    <= rej_now;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ----- src/i2c_bit_level_master.sv -----
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      i_in_valid/o_in_stall  i_in_data  (t_in_item: one tick + command)
// out      output     o_out_valid/i_out_stall o_out_data (t_out_item: line levels, status)
// cfg      input      APB psel/penable/pwrite 4 timing registers at byte offsets 0,4,8,12
//
// One tick is accepted per cycle while the queue is not full; it is written into the queue,
// and its result is registered in the output register when the sequencer pops it. A two-entry
// queue sits between the classifier and the sequencer, so up to two ticks are taken while the
// result register is stalled. Each tick is one pass through the sequencer state update.
// Reset is synchronous, active low; it sets the control and config registers, not the queue storage or result payload.
module i2c_bit_level_master (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire i2cbm_pkg::t_in_item i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output i2cbm_pkg::t_out_item     o_out_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import i2cbm_pkg::*;

    t_cfg      r_cfg;
    t_q_status q_status;
    t_entry    push_entry;
    t_entry    head_entry;
    logic      push;
    logic      pop;
    logic      cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_delay  <= LONG_DELAY_RST;
            r_cfg.short_delay <= SHORT_DELAY_RST;
            r_cfg.read_delay  <= READ_DELAY_RST;
            r_cfg.ack_timeout <= ACK_TIMEOUT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LONG_DELAY:  r_cfg.long_delay  <= pwdata[7:0];
                REG_SHORT_DELAY: r_cfg.short_delay <= pwdata[7:0];
                REG_READ_DELAY:  r_cfg.read_delay  <= pwdata[7:0];
                REG_ACK_TIMEOUT: r_cfg.ack_timeout <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LONG_DELAY:  prdata = {24'd0, r_cfg.long_delay};
            REG_SHORT_DELAY: prdata = {24'd0, r_cfg.short_delay};
            REG_READ_DELAY:  prdata = {24'd0, r_cfg.read_delay};
            REG_ACK_TIMEOUT: prdata = {24'd0, r_cfg.ack_timeout};
            default:         prdata = 32'd0;
        endcase
    end

    i2cbm_front u_front (
        .i_valid    (i_in_valid),
        .i_data     (i_in_data),
        .o_stall    (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    i2cbm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    i2cbm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_entry    (head_entry),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import i2cbm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int NEVER_ACK   = 1000;
    localparam int RANDOM_ACK  = -1;

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_STOP_A, SEQ_STOP_B,
        SEQ_TX_PRE, SEQ_TX_DATA, SEQ_TX_HIGH, SEQ_TX_LOW,
        SEQ_RX_LOW, SEQ_RX_HIGH,
        SEQ_ACK_LOW, SEQ_ACK_DATA, SEQ_ACK_DATA_X, SEQ_ACK_HIGH, SEQ_ACK_HIGH_X,
        SEQ_WAIT_REL, SEQ_WAIT_HIGH, SEQ_WAIT_POLL
    } t_seq;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data = '0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    i2c_bit_level_master DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timing registers as the bus master sees them
    logic [7:0] cfg_long, cfg_short, cfg_read, cfg_timeout;

    // sequencer state of the bus master
    t_seq       seq_q;
    logic [2:0] cmd_q;
    logic [7:0] tick_q;
    logic [3:0] bit_q;
    logic [7:0] shift_q;
    logic [7:0] poll_q;
    logic       ack_sel_q;
    logic       scl_q;
    logic       sda_rel_q;
    logic [7:0] rx_q;
    logic       done_now;
    logic       fail_now;

    t_out_item  expected_lines[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    bit         quiet = 1'b0;
    logic [2:0] last_cmd = CMD_STOP;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH cycle %0d: %s got %0h expected %0h",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic reset_line_model();
        cfg_long    = LONG_DELAY_RST;
        cfg_short   = SHORT_DELAY_RST;
        cfg_read    = READ_DELAY_RST;
        cfg_timeout = ACK_TIMEOUT_RST;
        seq_q       = SEQ_IDLE;
        cmd_q       = CMD_NONE;
        tick_q      = '0;
        bit_q       = '0;
        shift_q     = '0;
        poll_q      = '0;
        ack_sel_q   = 1'b0;
        scl_q       = 1'b0;
        sda_rel_q   = 1'b1;
        rx_q        = '0;
    endtask

    task automatic enter_phase(input t_seq ph, input logic [7:0] n);
        seq_q  = ph;
        tick_q = (n == 8'd0) ? 8'd1 : n;
    endtask

    task automatic finish_cmd();
        seq_q    = SEQ_IDLE;
        tick_q   = '0;
        done_now = 1'b1;
    endtask

    task automatic shift_out_bit();
        sda_rel_q = shift_q[7];
        shift_q   = {shift_q[6:0], 1'b0};
        enter_phase(SEQ_TX_DATA, cfg_long);
    endtask

    task automatic advance_phase(input logic sda);
        case (seq_q)
            SEQ_START_A: begin
                sda_rel_q = 1'b0;
                enter_phase(SEQ_START_B, cfg_long);
            end
            SEQ_START_B: begin
                scl_q = 1'b0;
                finish_cmd();
            end
            SEQ_STOP_A: begin
                sda_rel_q = 1'b1;
                enter_phase(SEQ_STOP_B, cfg_long);
            end
            SEQ_STOP_B: begin
                scl_q    = 1'b0;
                fail_now = (cmd_q == CMD_WAIT);
                finish_cmd();
            end
            SEQ_TX_PRE: shift_out_bit();
            SEQ_TX_DATA: begin
                scl_q = 1'b1;
                enter_phase(SEQ_TX_HIGH, cfg_long);
            end
            SEQ_TX_HIGH: begin
                scl_q = 1'b0;
                enter_phase(SEQ_TX_LOW, cfg_long);
            end
            SEQ_TX_LOW: begin
                bit_q = bit_q + 4'd1;
                if (bit_q < 4'd8) shift_out_bit();
                else finish_cmd();
            end
            SEQ_RX_LOW: begin
                scl_q   = 1'b1;
                shift_q = {shift_q[6:0], sda};
                enter_phase(SEQ_RX_HIGH, cfg_read);
            end
            SEQ_RX_HIGH: begin
                bit_q = bit_q + 4'd1;
                scl_q = 1'b0;
                if (bit_q < 4'd8) begin
                    sda_rel_q = 1'b1;
                    enter_phase(SEQ_RX_LOW, cfg_read);
                end else begin
                    rx_q = shift_q;
                    enter_phase(SEQ_ACK_LOW, cfg_short);
                end
            end
            SEQ_ACK_LOW: begin
                sda_rel_q = !ack_sel_q;
                enter_phase(SEQ_ACK_DATA, cfg_short);
            end
            SEQ_ACK_DATA: begin
                if (ack_sel_q) begin
                    enter_phase(SEQ_ACK_DATA_X, cfg_short);
                end else begin
                    scl_q = 1'b1;
                    enter_phase(SEQ_ACK_HIGH, cfg_short);
                end
            end
            SEQ_ACK_DATA_X: begin
                scl_q = 1'b1;
                enter_phase(SEQ_ACK_HIGH, cfg_short);
            end
            SEQ_ACK_HIGH: begin
                if (ack_sel_q) begin
                    enter_phase(SEQ_ACK_HIGH_X, cfg_short);
                end else begin
                    scl_q = 1'b0;
                    finish_cmd();
                end
            end
            SEQ_ACK_HIGH_X: begin
                scl_q = 1'b0;
                finish_cmd();
            end
            SEQ_WAIT_REL: begin
                scl_q = 1'b1;
                enter_phase(SEQ_WAIT_HIGH, cfg_short);
            end
            SEQ_WAIT_HIGH, SEQ_WAIT_POLL: begin
                if (!sda) begin
                    scl_q = 1'b0;
                    finish_cmd();
                end else if (poll_q >= cfg_timeout) begin
                    // give up: turn the poll into a stop condition
                    scl_q     = 1'b1;
                    sda_rel_q = 1'b0;
                    enter_phase(SEQ_STOP_A, cfg_long);
                end else begin
                    poll_q = poll_q + 8'd1;
                    enter_phase(SEQ_WAIT_POLL, cfg_short);
                end
            end
            default: finish_cmd();
        endcase
    endtask

    task automatic predict_bus_tick(input t_in_item it);
        logic      is_cmd;
        t_out_item res;
        is_cmd   = (it.action >= CMD_START) && (it.action <= CMD_WAIT);
        res      = '0;
        done_now = 1'b0;
        fail_now = 1'b0;
        if (seq_q == SEQ_IDLE) begin
            if (is_cmd) begin
                cmd_q     = it.action;
                bit_q     = '0;
                poll_q    = '0;
                shift_q   = it.tx_byte;
                ack_sel_q = it.send_ack;
                last_cmd  = it.action;
                case (it.action)
                    CMD_START: begin
                        sda_rel_q = 1'b1;
                        scl_q     = 1'b1;
                        enter_phase(SEQ_START_A, cfg_long);
                    end
                    CMD_STOP: begin
                        scl_q     = 1'b1;
                        sda_rel_q = 1'b0;
                        enter_phase(SEQ_STOP_A, cfg_long);
                    end
                    CMD_SEND: begin
                        scl_q = 1'b0;
                        enter_phase(SEQ_TX_PRE, cfg_short);
                    end
                    CMD_READ: begin
                        sda_rel_q = 1'b1;
                        scl_q     = 1'b0;
                        shift_q   = '0;
                        enter_phase(SEQ_RX_LOW, cfg_read);
                    end
                    default: begin
                        sda_rel_q = 1'b1;
                        enter_phase(SEQ_WAIT_REL, cfg_short);
                    end
                endcase
            end
        end else begin
            res.rejected = is_cmd;
            if (tick_q > 8'd0) tick_q = tick_q - 8'd1;
            if (tick_q == 8'd0) advance_phase(it.sda_in);
        end
        res.scl_level   = scl_q;
        res.sda_release = sda_rel_q;
        res.busy_res    = (seq_q != SEQ_IDLE);
        res.done_res    = done_now;
        res.rx_byte     = rx_q;
        res.ack_failed  = fail_now;
        expected_lines.push_back(res);
    endtask

    // SDA as the slave would drive it: ack after ack_at polls, or at random
    function automatic logic line_sda(input int ack_at);
        if (seq_q == SEQ_WAIT_HIGH || seq_q == SEQ_WAIT_POLL) begin
            if (ack_at < 0) return ($urandom_range(99) >= 30);
            return (int'(poll_q) >= ack_at) ? 1'b0 : 1'b1;
        end
        return 1'($urandom_range(1));
    endfunction

    task automatic send_tick(input t_in_item item);
        while (!quiet && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_bus_tick(item);
    endtask

    task automatic send_plain(input logic [2:0] act, input int ack_at);
        t_in_item it;
        it.action   = act;
        it.tx_byte  = 8'($urandom);
        it.send_ack = 1'($urandom_range(1));
        it.sda_in   = line_sda(ack_at);
        send_tick(it);
    endtask

    task automatic run_command(input logic [2:0] act, input logic [7:0] tx,
                               input logic ack, input int ack_at);
        t_in_item it;
        it.action   = act;
        it.tx_byte  = tx;
        it.send_ack = ack;
        it.sda_in   = 1'($urandom_range(1));
        send_tick(it);
        while (seq_q != SEQ_IDLE) send_plain(CMD_NONE, ack_at);
    endtask

    // finish the command in flight and hold off until every result is back
    task automatic settle();
        while (seq_q != SEQ_IDLE) send_plain(CMD_NONE, RANDOM_ACK);
        i_in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_LONG_DELAY:  cfg_long    = val;
            REG_SHORT_DELAY: cfg_short   = val;
            REG_READ_DELAY:  cfg_read    = val;
            default:         cfg_timeout = val;
        endcase
    endtask

    task automatic set_timing(input logic [7:0] long_t, input logic [7:0] short_t,
                              input logic [7:0] read_t, input logic [7:0] limit);
        settle();
        write_reg(REG_LONG_DELAY, long_t);
        write_reg(REG_SHORT_DELAY, short_t);
        write_reg(REG_READ_DELAY, read_t);
        write_reg(REG_ACK_TIMEOUT, limit);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_idle_ticks();
        send_plain(CMD_NONE, RANDOM_ACK);
        send_plain(3'd6, RANDOM_ACK);
        send_plain(3'd7, RANDOM_ACK);
        send_plain(CMD_NONE, RANDOM_ACK);
    endtask

    task automatic test_start_stop();
        run_command(CMD_START, 8'h00, 1'b0, RANDOM_ACK);
        run_command(CMD_STOP, 8'hFF, 1'b1, RANDOM_ACK);
    endtask

    task automatic test_send_byte();
        run_command(CMD_START, 8'h00, 1'b0, RANDOM_ACK);
        run_command(CMD_SEND, 8'h00, 1'b0, RANDOM_ACK);
        run_command(CMD_SEND, 8'hFF, 1'b1, RANDOM_ACK);
        run_command(CMD_SEND, 8'hA5, 1'b0, RANDOM_ACK);
    endtask

    task automatic test_read_byte();
        run_command(CMD_READ, 8'h00, 1'b1, RANDOM_ACK);
        run_command(CMD_READ, 8'hFF, 1'b0, RANDOM_ACK);
        run_command(CMD_STOP, 8'h00, 1'b0, RANDOM_ACK);
    endtask

    task automatic test_wait_ack();
        set_timing(8'd5, 8'd2, 8'd4, 8'd3);
        run_command(CMD_WAIT, 8'h00, 1'b0, 0);
        run_command(CMD_WAIT, 8'h00, 1'b0, 2);
        run_command(CMD_WAIT, 8'h00, 1'b0, NEVER_ACK);
        // a zero limit fails on the first high poll
        set_timing(8'd5, 8'd2, 8'd4, 8'd0);
        run_command(CMD_WAIT, 8'h00, 1'b1, NEVER_ACK);
        run_command(CMD_WAIT, 8'h00, 1'b1, 0);
    endtask

    task automatic test_rejects();
        set_timing(LONG_DELAY_RST, SHORT_DELAY_RST, READ_DELAY_RST, ACK_TIMEOUT_RST);
        run_command(CMD_START, 8'h00, 1'b0, RANDOM_ACK);
        send_plain(CMD_STOP, RANDOM_ACK);
        for (int a = 1; a < 8; a++) send_plain(3'(a), RANDOM_ACK);
        // a command on the finishing tick still counts as busy
        while (!(seq_q == SEQ_STOP_B && tick_q == 8'd1)) send_plain(CMD_NONE, RANDOM_ACK);
        send_plain(CMD_SEND, RANDOM_ACK);
        send_plain(CMD_NONE, RANDOM_ACK);
    endtask

    task automatic test_timing_extremes();
        set_timing(8'd1, 8'd1, 8'd1, 8'd1);
        run_command(CMD_START, 8'h00, 1'b0, RANDOM_ACK);
        run_command(CMD_SEND, 8'($urandom), 1'b0, RANDOM_ACK);
        run_command(CMD_WAIT, 8'h00, 1'b0, 0);
        run_command(CMD_READ, 8'h00, 1'b1, RANDOM_ACK);
        run_command(CMD_STOP, 8'h00, 1'b0, RANDOM_ACK);
        // zero delays behave as one tick
        set_timing(8'd0, 8'd0, 8'd0, 8'd0);
        run_command(CMD_START, 8'h00, 1'b0, RANDOM_ACK);
        run_command(CMD_SEND, 8'($urandom), 1'b1, RANDOM_ACK);
        run_command(CMD_WAIT, 8'h00, 1'b0, NEVER_ACK);
        run_command(CMD_READ, 8'h00, 1'b0, RANDOM_ACK);
        run_command(CMD_STOP, 8'h00, 1'b0, RANDOM_ACK);
        set_timing(8'd255, 8'd1, 8'd1, 8'd255);
        run_command(CMD_STOP, 8'h00, 1'b0, RANDOM_ACK);
        run_command(CMD_WAIT, 8'h00, 1'b0, 0);
    endtask

    // next command of a plausible transfer: start, address, ack, data..., stop
    function automatic logic [2:0] next_flow_cmd();
        int roll;
        roll = $urandom_range(99);
        case (last_cmd)
            CMD_START: return CMD_SEND;
            CMD_SEND:  return CMD_WAIT;
            CMD_WAIT:  return (roll < 40) ? CMD_SEND : (roll < 70) ? CMD_READ : CMD_STOP;
            CMD_READ:  return (roll < 50) ? CMD_READ : CMD_STOP;
            default:   return CMD_START;
        endcase
    endfunction

    task automatic random_ticks(input int count);
        t_in_item it;
        int       roll;
        for (int k = 0; k < count; k++) begin
            it.tx_byte  = 8'($urandom);
            it.send_ack = 1'($urandom_range(1));
            it.sda_in   = line_sda(RANDOM_ACK);
            roll        = $urandom_range(99);
            if (seq_q == SEQ_IDLE) begin
                if (roll < 70) it.action = next_flow_cmd();
                else if (roll < 85) it.action = 3'($urandom_range(CMD_WAIT, CMD_START));
                else it.action = ($urandom_range(2) == 0) ? CMD_NONE : 3'($urandom_range(7, 6));
            end else begin
                it.action = (roll < 6) ? 3'($urandom_range(7)) : CMD_NONE;
            end
            send_tick(it);
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            quiet = (p == 2);
            if (p == 4) set_timing(8'd1, 8'd1, 8'd1, 8'd255);
            else set_timing(8'($urandom_range(4)), 8'($urandom_range(3)),
                            8'($urandom_range(4)), 8'($urandom_range(6)));
            random_ticks(100);
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_lines.size() == 0) begin
                report_mismatch("result with nothing expected", 8'd0, 8'd0);
            end else begin
                want = expected_lines.pop_front();
                if (o_out_data.scl_level !== want.scl_level)
                    report_mismatch("scl_level", 8'(o_out_data.scl_level),
                                    8'(want.scl_level));
                if (o_out_data.sda_release !== want.sda_release)
                    report_mismatch("sda_release", 8'(o_out_data.sda_release),
                                    8'(want.sda_release));
                if (o_out_data.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 8'(o_out_data.busy_res),
                                    8'(want.busy_res));
                if (o_out_data.done_res !== want.done_res)
                    report_mismatch("done_res", 8'(o_out_data.done_res),
                                    8'(want.done_res));
                if (o_out_data.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", o_out_data.rx_byte, want.rx_byte);
                if (o_out_data.ack_failed !== want.ack_failed)
                    report_mismatch("ack_failed", 8'(o_out_data.ack_failed),
                                    8'(want.ack_failed));
                if (o_out_data.rejected !== want.rejected)
                    report_mismatch("rejected", 8'(o_out_data.rejected),
                                    8'(want.rejected));
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < 38);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("i2c_bit_level_master test failed");
            $finish;
        end
    end

    initial begin
        reset_line_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_ticks();
        test_start_stop();
        test_send_byte();
        test_read_byte();
        test_wait_ack();
        test_rejects();
        test_timing_extremes();
        test_random();
        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_lines.size() == 0) begin
            $display("i2c_bit_level_master test passed");
        end else begin
            $display("i2c_bit_level_master test failed");
        end
        $finish;
    end

endmodule
